>>> src/fgn_pkg.sv
`default_nettype none
package fgn_pkg;

	// grid and field sizes
	localparam int MAX_NODES   = 64;
	localparam int NODE_W      = $clog2(MAX_NODES);
	localparam int ADDR_W      = 2 * NODE_W;
	localparam int DEPTH       = MAX_NODES * MAX_NODES;
	localparam int MAX_OCTAVES = 16;
	localparam int OCT_W       = $clog2(MAX_OCTAVES);
	localparam int OCT_CNT_W   = 5;
	localparam int NCFG_W      = 7;
	localparam int GRAD_W      = 16;
	localparam int PT_W        = 24;
	localparam int FREQ_W      = 16;
	localparam int AMP_W       = 16;
	localparam int HEIGHT_W    = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	// datapath widths
	localparam int FRAC_POS  = 24;
	localparam int RES_W     = NODE_W + FRAC_POS;
	localparam int V_W       = PT_W + FREQ_W;
	localparam int VHI_W     = V_W - FRAC_POS;
	localparam int STEP_W    = $clog2(VHI_W);
	localparam int FRAC_W    = 17;
	localparam int OFS_W     = FRAC_W + 1;
	localparam int MA_W      = 38;
	localparam int MB_W      = 18;
	localparam int PROD_W    = MA_W + MB_W;
	localparam int ACC_W     = PROD_W;
	localparam int ACC_SHIFT = 30;

	// fade table
	localparam int FADE_BITS = 8;
	localparam int FADE_N    = 1 << FADE_BITS;
	localparam int FIDX_W    = FADE_BITS + 1;

	localparam logic [0:0] REQ_WRITE = 1'b0;
	localparam logic [0:0] REQ_EVAL  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NODES_X    = 3'd0,
		REG_NODES_Y    = 3'd1,
		REG_OCTAVES    = 3'd2,
		REG_START_AMP  = 3'd3,
		REG_START_FREQ = 3'd4
	} cfg_reg_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_MULPX, ST_MULPY, ST_DIVINIT, ST_DIVSTEP, ST_CELL, ST_ADDR,
		ST_MULX, ST_MULY, ST_DOT, ST_LMUL, ST_LADD, ST_AMUL, ST_ACC, ST_DONE
	} ctrl_state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_WRITE, OP_LOAD, OP_MULPX, OP_MULPY, OP_DIVINIT, OP_DIVSTEP,
		OP_CELL, OP_ADDR, OP_MULX, OP_MULY, OP_DOT, OP_LMUL, OP_LADD, OP_AMUL,
		OP_ACC_RES
	} dp_op_t;

	typedef struct packed {
		dp_op_t            op;
		logic [STEP_W-1:0] step;
		logic [1:0]        corner;
		logic [1:0]        lerp;
		logic [OCT_W-1:0]  octave;
		logic              result;
	} dp_cmd_t;

	typedef struct packed {
		logic [OCT_CNT_W-1:0] oct_cnt;
	} dp_status_t;

	typedef logic [FRAC_W-1:0] fade_tab_t [0:FADE_N];

	localparam longint unsigned Q30_ONE = 64'd1 << 30;
	localparam longint unsigned PI_Q30  = 64'd3373259369;

	// (1 - cos(pi*t)) / 2 in Q.16, sine by a degree 9 Taylor polynomial in Q.30
	function automatic fade_tab_t build_fade();
		fade_tab_t t;
		longint unsigned x, x2, p, s, f;
		int k;
		for (k = FADE_N / 2; k <= FADE_N; k++) begin
			x  = (PI_Q30 * longint'(k - FADE_N / 2)) >> FADE_BITS;
			x2 = (x * x) >> 30;
			p  = Q30_ONE - x2 / 72;
			p  = Q30_ONE - ((x2 * p) >> 30) / 42;
			p  = Q30_ONE - ((x2 * p) >> 30) / 20;
			p  = Q30_ONE - ((x2 * p) >> 30) / 6;
			s  = (x * p) >> 30;
			f  = (Q30_ONE + s + (64'd1 << 14)) >> 15;
			t[k] = (f > 64'd65536) ? FRAC_W'(65536) : FRAC_W'(f);
		end
		for (k = 0; k < FADE_N / 2; k++) begin
			t[k] = FRAC_W'(65536) - t[FADE_N - k];
		end
		t[0]      = '0;
		t[FADE_N] = FRAC_W'(65536);
		return t;
	endfunction

	localparam fade_tab_t FADE_TAB = build_fade();

endpackage
`default_nettype wire

>>> src/fgn_req_if.sv
`default_nettype none
interface fgn_req_if;
	logic                               valid;
	logic                               ready;
	logic                               req_type;
	logic [fgn_pkg::NODE_W-1:0]         node_col;
	logic [fgn_pkg::NODE_W-1:0]         node_row;
	logic signed [fgn_pkg::GRAD_W-1:0]  grad_x;
	logic signed [fgn_pkg::GRAD_W-1:0]  grad_y;
	logic [fgn_pkg::PT_W-1:0]           point_x;
	logic [fgn_pkg::PT_W-1:0]           point_y;

	modport source (output valid, req_type, node_col, node_row, grad_x, grad_y,
		point_x, point_y, input ready);
	modport sink (input valid, req_type, node_col, node_row, grad_x, grad_y,
		point_x, point_y, output ready);
endinterface
`default_nettype wire

>>> src/fgn_rsp_if.sv
`default_nettype none
interface fgn_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [fgn_pkg::HEIGHT_W-1:0]   height;

	modport source (output valid, height, input ready);
	modport sink (input valid, height, output ready);
endinterface
`default_nettype wire

>>> src/fgn_ram.sv
`default_nettype none
module fgn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

>>> src/fgn_ctrl.sv
`default_nettype none
module fgn_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	input  wire logic                req_type,
	input  wire logic                rsp_ready,
	input  wire fgn_pkg::dp_status_t status,
	output logic                     req_ready,
	output logic                     rsp_valid,
	output fgn_pkg::dp_cmd_t         cmd
);
	fgn_pkg::ctrl_state_t state_q, state_d;
	logic [fgn_pkg::STEP_W-1:0] step_q;
	logic [1:0]                 corner_q;
	logic [1:0]                 lerp_q;
	logic [fgn_pkg::OCT_W-1:0]  oct_q;
	logic                       out_valid_q;
	logic                       last_oct;
	logic                       out_free;

	assign last_oct = (fgn_pkg::OCT_CNT_W'(oct_q) + fgn_pkg::OCT_CNT_W'(1)) == status.oct_cnt;
	assign out_free = !out_valid_q || rsp_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fgn_pkg::ST_IDLE: begin
				if (req_valid && req_type == fgn_pkg::REQ_EVAL) state_d = fgn_pkg::ST_MULPX;
			end
			fgn_pkg::ST_MULPX:   state_d = fgn_pkg::ST_MULPY;
			fgn_pkg::ST_MULPY:   state_d = fgn_pkg::ST_DIVINIT;
			fgn_pkg::ST_DIVINIT: state_d = fgn_pkg::ST_DIVSTEP;
			fgn_pkg::ST_DIVSTEP: begin
				if (step_q == fgn_pkg::STEP_W'(fgn_pkg::VHI_W - 1)) begin
					state_d = (status.oct_cnt == '0) ? fgn_pkg::ST_DONE : fgn_pkg::ST_CELL;
				end
			end
			fgn_pkg::ST_CELL: state_d = fgn_pkg::ST_ADDR;
			fgn_pkg::ST_ADDR: state_d = fgn_pkg::ST_MULX;
			fgn_pkg::ST_MULX: state_d = fgn_pkg::ST_MULY;
			fgn_pkg::ST_MULY: state_d = fgn_pkg::ST_DOT;
			fgn_pkg::ST_DOT:  state_d = (corner_q == 2'd3) ? fgn_pkg::ST_LMUL : fgn_pkg::ST_ADDR;
			fgn_pkg::ST_LMUL: state_d = fgn_pkg::ST_LADD;
			fgn_pkg::ST_LADD: state_d = (lerp_q == 2'd2) ? fgn_pkg::ST_AMUL : fgn_pkg::ST_LMUL;
			fgn_pkg::ST_AMUL: state_d = fgn_pkg::ST_ACC;
			fgn_pkg::ST_ACC:  state_d = last_oct ? fgn_pkg::ST_DONE : fgn_pkg::ST_CELL;
			fgn_pkg::ST_DONE: begin
				if (out_free) state_d = fgn_pkg::ST_IDLE;
			end
			default: state_d = fgn_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready  = 1'b0;
		cmd.op     = fgn_pkg::OP_NONE;
		cmd.step   = step_q;
		cmd.corner = corner_q;
		cmd.lerp   = lerp_q;
		cmd.octave = oct_q;
		cmd.result = 1'b0;
		unique case (state_q)
			fgn_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.op = (req_type == fgn_pkg::REQ_EVAL) ? fgn_pkg::OP_LOAD : fgn_pkg::OP_WRITE;
				end
			end
			fgn_pkg::ST_MULPX:   cmd.op = fgn_pkg::OP_MULPX;
			fgn_pkg::ST_MULPY:   cmd.op = fgn_pkg::OP_MULPY;
			fgn_pkg::ST_DIVINIT: cmd.op = fgn_pkg::OP_DIVINIT;
			fgn_pkg::ST_DIVSTEP: cmd.op = fgn_pkg::OP_DIVSTEP;
			fgn_pkg::ST_CELL:    cmd.op = fgn_pkg::OP_CELL;
			fgn_pkg::ST_ADDR:    cmd.op = fgn_pkg::OP_ADDR;
			fgn_pkg::ST_MULX:    cmd.op = fgn_pkg::OP_MULX;
			fgn_pkg::ST_MULY:    cmd.op = fgn_pkg::OP_MULY;
			fgn_pkg::ST_DOT:     cmd.op = fgn_pkg::OP_DOT;
			fgn_pkg::ST_LMUL:    cmd.op = fgn_pkg::OP_LMUL;
			fgn_pkg::ST_LADD:    cmd.op = fgn_pkg::OP_LADD;
			fgn_pkg::ST_AMUL:    cmd.op = fgn_pkg::OP_AMUL;
			fgn_pkg::ST_ACC:     cmd.op = fgn_pkg::OP_ACC_RES;
			fgn_pkg::ST_DONE: begin
				cmd.op     = fgn_pkg::OP_ACC_RES;
				cmd.result = out_free;
			end
			default: cmd.op = fgn_pkg::OP_NONE;
		endcase
	end

	assign rsp_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fgn_pkg::ST_IDLE;
			step_q      <= '0;
			corner_q    <= '0;
			lerp_q      <= '0;
			oct_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == fgn_pkg::ST_DIVINIT) step_q <= '0;
			else if (state_q == fgn_pkg::ST_DIVSTEP) step_q <= step_q + 1'b1;
			if (state_q == fgn_pkg::ST_CELL) corner_q <= '0;
			else if (state_q == fgn_pkg::ST_DOT) corner_q <= corner_q + 1'b1;
			if (state_q == fgn_pkg::ST_CELL) lerp_q <= '0;
			else if (state_q == fgn_pkg::ST_LADD) lerp_q <= lerp_q + 1'b1;
			if (state_q == fgn_pkg::ST_DIVINIT) oct_q <= '0;
			else if (state_q == fgn_pkg::ST_ACC) oct_q <= oct_q + 1'b1;
			if (cmd.result) out_valid_q <= 1'b1;
			else if (rsp_ready) out_valid_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

>>> src/fgn_dp.sv
`default_nettype none
module fgn_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire fgn_pkg::dp_cmd_t                  cmd,
	input  wire logic [fgn_pkg::NODE_W-1:0]        node_col,
	input  wire logic [fgn_pkg::NODE_W-1:0]        node_row,
	input  wire logic signed [fgn_pkg::GRAD_W-1:0] grad_x,
	input  wire logic signed [fgn_pkg::GRAD_W-1:0] grad_y,
	input  wire logic [fgn_pkg::PT_W-1:0]          point_x,
	input  wire logic [fgn_pkg::PT_W-1:0]          point_y,
	input  wire logic                              cfg_we,
	input  wire logic [fgn_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  wire logic [fgn_pkg::CFG_DATA_W-1:0]    cfg_data,
	output fgn_pkg::dp_status_t                    status,
	output logic [fgn_pkg::HEIGHT_W-1:0]           height
);
	localparam int NW = fgn_pkg::NODE_W;
	localparam int FP = fgn_pkg::FRAC_POS;
	localparam int RW = fgn_pkg::RES_W;

	// configuration
	logic [fgn_pkg::NCFG_W-1:0]    nodes_x_q, nodes_y_q;
	logic [fgn_pkg::OCT_CNT_W-1:0] octaves_q;
	logic [fgn_pkg::AMP_W-1:0]     amp_q;
	logic [fgn_pkg::FREQ_W-1:0]    freq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nodes_x_q <= fgn_pkg::NCFG_W'(64);
			nodes_y_q <= fgn_pkg::NCFG_W'(64);
			octaves_q <= fgn_pkg::OCT_CNT_W'(4);
			amp_q     <= fgn_pkg::AMP_W'(8192);
			freq_q    <= fgn_pkg::FREQ_W'(256);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				fgn_pkg::REG_NODES_X:    nodes_x_q <= cfg_data[fgn_pkg::NCFG_W-1:0];
				fgn_pkg::REG_NODES_Y:    nodes_y_q <= cfg_data[fgn_pkg::NCFG_W-1:0];
				fgn_pkg::REG_OCTAVES:    octaves_q <= cfg_data[fgn_pkg::OCT_CNT_W-1:0];
				fgn_pkg::REG_START_AMP:  amp_q     <= cfg_data;
				fgn_pkg::REG_START_FREQ: freq_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp node counts to 2..MAX_NODES, octaves to MAX_OCTAVES
	logic [fgn_pkg::NCFG_W-1:0] nx_c, ny_c;
	logic [NW-1:0]              dx, dy, capx, capy;
	logic [RW-1:0]              topx, topy;

	always_comb begin
		nx_c = nodes_x_q;
		if (nodes_x_q < fgn_pkg::NCFG_W'(2)) nx_c = fgn_pkg::NCFG_W'(2);
		else if (nodes_x_q > fgn_pkg::NCFG_W'(fgn_pkg::MAX_NODES))
			nx_c = fgn_pkg::NCFG_W'(fgn_pkg::MAX_NODES);
		ny_c = nodes_y_q;
		if (nodes_y_q < fgn_pkg::NCFG_W'(2)) ny_c = fgn_pkg::NCFG_W'(2);
		else if (nodes_y_q > fgn_pkg::NCFG_W'(fgn_pkg::MAX_NODES))
			ny_c = fgn_pkg::NCFG_W'(fgn_pkg::MAX_NODES);
		status.oct_cnt = (octaves_q > fgn_pkg::OCT_CNT_W'(fgn_pkg::MAX_OCTAVES)) ?
			fgn_pkg::OCT_CNT_W'(fgn_pkg::MAX_OCTAVES) : octaves_q;
	end

	assign dx   = NW'(nx_c - fgn_pkg::NCFG_W'(1));
	assign dy   = NW'(ny_c - fgn_pkg::NCFG_W'(1));
	assign capx = NW'(nx_c - fgn_pkg::NCFG_W'(2));
	assign capy = NW'(ny_c - fgn_pkg::NCFG_W'(2));
	assign topx = {dx, {FP{1'b0}}};
	assign topy = {dy, {FP{1'b0}}};

	// datapath registers
	logic [fgn_pkg::PT_W-1:0]          pt_x_q, pt_y_q;
	logic [fgn_pkg::V_W-1:0]           vx_q;
	logic                              nzx_q, nzy_q;
	logic [RW-1:0]                     rx_q, ry_q;
	logic [NW-1:0]                     ix_q, iy_q;
	logic [fgn_pkg::FRAC_W-1:0]        fx_q, fy_q, wx_q, wy_q;
	logic signed [fgn_pkg::PROD_W-1:0] prod_q;
	logic signed [fgn_pkg::MA_W-1:0]   dot_q;
	logic signed [fgn_pkg::MA_W-1:0]   g_q [0:3];
	logic signed [fgn_pkg::ACC_W-1:0]  acc_q;
	logic [2*fgn_pkg::GRAD_W-1:0]      rdata;

	// gradient store
	logic [fgn_pkg::ADDR_W-1:0] raddr;
	assign raddr = {NW'(iy_q + NW'(cmd.corner[1])), NW'(ix_q + NW'(cmd.corner[0]))};

	fgn_ram #(.WIDTH(2 * fgn_pkg::GRAD_W), .DEPTH(fgn_pkg::DEPTH)) u_store (
		.clk   (clk),
		.we    (cmd.op == fgn_pkg::OP_WRITE),
		.waddr ({node_row, node_col}),
		.wdata ({grad_x, grad_y}),
		.re    (cmd.op == fgn_pkg::OP_ADDR),
		.raddr (raddr),
		.rdata (rdata)
	);

	// shared multiplier operand select
	logic signed [fgn_pkg::MA_W-1:0]  ma, la, lb;
	logic signed [fgn_pkg::MB_W-1:0]  mb;
	logic signed [fgn_pkg::OFS_W-1:0] fxs, fys, ox, oy;
	logic [fgn_pkg::FRAC_W-1:0]       lw;

	assign fxs = $signed({1'b0, fx_q});
	assign fys = $signed({1'b0, fy_q});
	assign ox  = cmd.corner[0] ? (fgn_pkg::OFS_W'(65536) - fxs) : (-fxs);
	assign oy  = cmd.corner[1] ? (fgn_pkg::OFS_W'(65536) - fys) : (-fys);

	always_comb begin
		la = g_q[0];
		lb = g_q[1];
		lw = wx_q;
		case (cmd.lerp)
			2'd1: begin
				la = g_q[2];
				lb = g_q[3];
			end
			2'd2: begin
				lb = g_q[2];
				lw = wy_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.op)
			fgn_pkg::OP_MULPX: begin
				ma = $signed(fgn_pkg::MA_W'(pt_x_q));
				mb = $signed(fgn_pkg::MB_W'(freq_q));
			end
			fgn_pkg::OP_MULPY: begin
				ma = $signed(fgn_pkg::MA_W'(pt_y_q));
				mb = $signed(fgn_pkg::MB_W'(freq_q));
			end
			fgn_pkg::OP_MULX: begin
				ma = fgn_pkg::MA_W'(ox);
				mb = fgn_pkg::MB_W'($signed(rdata[2*fgn_pkg::GRAD_W-1:fgn_pkg::GRAD_W]));
			end
			fgn_pkg::OP_MULY: begin
				ma = fgn_pkg::MA_W'(oy);
				mb = fgn_pkg::MB_W'($signed(rdata[fgn_pkg::GRAD_W-1:0]));
			end
			fgn_pkg::OP_LMUL: begin
				ma = lb - la;
				mb = $signed(fgn_pkg::MB_W'(lw));
			end
			fgn_pkg::OP_AMUL: begin
				ma = g_q[0];
				mb = $signed(fgn_pkg::MB_W'(amp_q));
			end
			default: ;
		endcase
	end

	// cell, fraction and fade lookup
	logic [RW-1:0]              cx, cy, cxd, cyd;
	logic [NW-1:0]              ix, iy;
	logic [fgn_pkg::FRAC_W-1:0] fxr, fyr;

	always_comb begin
		cx = '0;
		if (nzx_q) cx = (rx_q == '0) ? topx : rx_q;
		cy = '0;
		if (nzy_q) cy = (ry_q == '0) ? topy : ry_q;
		ix  = (cx[RW-1:FP] > capx) ? capx : cx[RW-1:FP];
		iy  = (cy[RW-1:FP] > capy) ? capy : cy[RW-1:FP];
		cxd = cx - {ix, {FP{1'b0}}};
		cyd = cy - {iy, {FP{1'b0}}};
	end

	assign fxr = fx_q + fgn_pkg::FRAC_W'(1 << (15 - fgn_pkg::FADE_BITS));
	assign fyr = fy_q + fgn_pkg::FRAC_W'(1 << (15 - fgn_pkg::FADE_BITS));

	// division remainder step and octave doubling
	logic [fgn_pkg::VHI_W-1:0] vxhi, vyhi;
	logic [NW:0]               rsx, rsy;
	logic [RW:0]               d2x, d2y;

	assign vxhi = vx_q[fgn_pkg::V_W-1:FP];
	assign rsx  = {rx_q[RW-1:FP], vxhi[fgn_pkg::STEP_W'(fgn_pkg::VHI_W - 1) - cmd.step]};
	assign rsy  = {ry_q[RW-1:FP], vyhi[fgn_pkg::STEP_W'(fgn_pkg::VHI_W - 1) - cmd.step]};
	assign d2x  = {rx_q, 1'b0};
	assign d2y  = {ry_q, 1'b0};

	logic [fgn_pkg::V_W-1:0] vy_q;
	assign vyhi = vy_q[fgn_pkg::V_W-1:FP];

	// result clamp to 0..2
	localparam logic signed [fgn_pkg::ACC_W-1:0] ACC_MAX = fgn_pkg::ACC_W'(2) <<< 44;
	logic [fgn_pkg::HEIGHT_W-1:0] hclamp;

	always_comb begin
		if (acc_q < 0) hclamp = '0;
		else if (acc_q > ACC_MAX) hclamp = fgn_pkg::HEIGHT_W'(32768);
		else hclamp = acc_q[fgn_pkg::ACC_SHIFT +: fgn_pkg::HEIGHT_W];
	end

	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
		case (cmd.op)
			fgn_pkg::OP_LOAD: begin
				pt_x_q <= point_x;
				pt_y_q <= point_y;
			end
			fgn_pkg::OP_MULPY: vx_q <= prod_q[fgn_pkg::V_W-1:0];
			fgn_pkg::OP_DIVINIT: begin
				vy_q  <= prod_q[fgn_pkg::V_W-1:0];
				nzx_q <= vx_q != '0;
				nzy_q <= prod_q[fgn_pkg::V_W-1:0] != '0;
				rx_q  <= {{NW{1'b0}}, vx_q[FP-1:0]};
				ry_q  <= {{NW{1'b0}}, prod_q[FP-1:0]};
				acc_q <= fgn_pkg::ACC_W'(amp_q) <<< fgn_pkg::ACC_SHIFT;
			end
			fgn_pkg::OP_DIVSTEP: begin
				rx_q[RW-1:FP] <= (rsx >= {1'b0, dx}) ? NW'(rsx - {1'b0, dx}) : rsx[NW-1:0];
				ry_q[RW-1:FP] <= (rsy >= {1'b0, dy}) ? NW'(rsy - {1'b0, dy}) : rsy[NW-1:0];
			end
			fgn_pkg::OP_CELL: begin
				ix_q <= ix;
				iy_q <= iy;
				fx_q <= cxd[FP:FP-fgn_pkg::FRAC_W+1];
				fy_q <= cyd[FP:FP-fgn_pkg::FRAC_W+1];
			end
			fgn_pkg::OP_ADDR: begin
				wx_q <= fgn_pkg::FADE_TAB[fxr[fgn_pkg::FRAC_W-1 -: fgn_pkg::FIDX_W]];
				wy_q <= fgn_pkg::FADE_TAB[fyr[fgn_pkg::FRAC_W-1 -: fgn_pkg::FIDX_W]];
			end
			fgn_pkg::OP_MULY: dot_q <= prod_q[fgn_pkg::MA_W-1:0];
			fgn_pkg::OP_DOT:  g_q[cmd.corner] <= dot_q + prod_q[fgn_pkg::MA_W-1:0];
			fgn_pkg::OP_LADD: begin
				if (cmd.lerp == 2'd1) g_q[2] <= la + fgn_pkg::MA_W'(prod_q >>> 16);
				else g_q[0] <= la + fgn_pkg::MA_W'(prod_q >>> 16);
			end
			fgn_pkg::OP_ACC_RES: begin
				if (cmd.result) begin
					height <= hclamp;
				end else begin
					acc_q <= acc_q + (prod_q >>> cmd.octave);
					rx_q  <= (d2x >= {1'b0, topx}) ? RW'(d2x - {1'b0, topx}) : d2x[RW-1:0];
					ry_q  <= (d2y >= {1'b0, topy}) ? RW'(d2y - {1'b0, topy}) : d2y[RW-1:0];
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

>>> src/fractal_gradient_noise_core.sv
`default_nettype none
// Fractal 2D gradient noise evaluator.
// req channel: a word with req_type = 0 writes one gradient (grad_x, grad_y,
//   signed Q1.14) at node (node_col, node_row); it is stored when taken and
//   gives no result. A word with req_type = 1 evaluates point (point_x,
//   point_y, unsigned Q8.16) and gives one height word (unsigned Q2.14, 0..2).
// rsp channel: one height word per evaluate, in request order.
// Config port: cfg_we/cfg_idx/cfg_data write nodes_x, nodes_y, octave_count,
//   start_amplitude, start_frequency (index 0..4); write only while idle.
// Sequence: an evaluate runs two multiplies, a 16-step remainder search, then
//   per octave four corner reads and dot products, three blends and one
//   accumulate, until its height is loaded into the output register; all
//   share one multiplier and the single read port of the gradient store.
//   One request is worked at a time; a new word is taken once the last one
//   finishes.
// Reset clears the sequencer and restores the register defaults; the
//   gradient store is not cleared, so load every node used before evaluating.
// A stalled receiver holds the height word in the output register; a new
//   request may still be taken, but its result waits until that word drains.
module fractal_gradient_noise_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	fgn_req_if.sink                                req,
	fgn_rsp_if.source                              rsp,
	input  wire logic                              cfg_we,
	input  wire logic [fgn_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  wire logic [fgn_pkg::CFG_DATA_W-1:0]    cfg_data
);
	fgn_pkg::dp_cmd_t    cmd;
	fgn_pkg::dp_status_t status;

	// sequencer: handshakes, counters, commands
	fgn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req.req_type),
		.rsp_ready (rsp.ready),
		.status    (status),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.cmd       (cmd)
	);

	// datapath: config, gradient store, multiplier, accumulator, output word
	fgn_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.node_col (req.node_col),
		.node_row (req.node_row),
		.grad_x   (req.grad_x),
		.grad_y   (req.grad_y),
		.point_x  (req.point_x),
		.point_y  (req.point_y),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.status   (status),
		.height   (rsp.height)
	);
endmodule
`default_nettype wire

>>> verif/tb.sv
module tb;
	// Register indexes past the last one; a write there must change nothing.
	localparam logic [fgn_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [fgn_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	// Generous stop: every evaluate at its slowest is far below this.
	localparam int CYCLE_LIMIT = 3000000;
	// Drain wait after the last height, letting a trailing write settle.
	localparam int SETTLE_CYCLES = 40;
	// Side of the grid corner loaded up front; every evaluate reads inside it.
	localparam int LOAD_SIDE = 24;

	// One request word as the testbench sees it.
	typedef struct {
		logic [0:0]                        kind;
		logic [fgn_pkg::NODE_W-1:0]        col;
		logic [fgn_pkg::NODE_W-1:0]        row;
		logic signed [fgn_pkg::GRAD_W-1:0] gx;
		logic signed [fgn_pkg::GRAD_W-1:0] gy;
		logic [fgn_pkg::PT_W-1:0]          px;
		logic [fgn_pkg::PT_W-1:0]          py;
	} noise_req_t;

	// Predicts heights from its own copy of the gradient grid and the
	// registers, and keeps the heights still owed by the block.
	class height_scoreboard;
		logic signed [fgn_pkg::GRAD_W-1:0] grid_gx [fgn_pkg::DEPTH];
		logic signed [fgn_pkg::GRAD_W-1:0] grid_gy [fgn_pkg::DEPTH];
		longint unsigned blend_w [0:fgn_pkg::FADE_N];
		int unsigned reg_nx, reg_ny, reg_oct, reg_amp, reg_freq;
		logic [fgn_pkg::HEIGHT_W-1:0] owed_heights [$];
		int mismatches, heights_seen, writes_seen, evals_seen;

		function new();
			longint unsigned ang, sq, poly, sn, v;
			int k;
			reg_nx = 64; reg_ny = 64; reg_oct = 4; reg_amp = 8192; reg_freq = 256;
			// cosine fade (1-cos(pi t))/2 through an integer sine series
			for (k = fgn_pkg::FADE_N / 2; k <= fgn_pkg::FADE_N; k++) begin
				ang  = (64'd3373259369 * longint'(k - fgn_pkg::FADE_N / 2))
					>> fgn_pkg::FADE_BITS;
				sq   = (ang * ang) >> 30;
				poly = (64'd1 << 30) - sq / 72;
				poly = (64'd1 << 30) - ((sq * poly) >> 30) / 42;
				poly = (64'd1 << 30) - ((sq * poly) >> 30) / 20;
				poly = (64'd1 << 30) - ((sq * poly) >> 30) / 6;
				sn   = (ang * poly) >> 30;
				v    = ((64'd1 << 30) + sn + (64'd1 << 14)) >> 15;
				blend_w[k] = (v > 65536) ? 65536 : v;
			end
			for (k = 0; k < fgn_pkg::FADE_N / 2; k++)
				blend_w[k] = 65536 - blend_w[fgn_pkg::FADE_N - k];
			blend_w[0] = 0;
			blend_w[fgn_pkg::FADE_N] = 65536;
		endfunction

		function void set_reg(logic [fgn_pkg::CFG_IDX_W-1:0] idx,
				logic [fgn_pkg::CFG_DATA_W-1:0] d);
			case (idx)
				fgn_pkg::REG_NODES_X:    reg_nx = d[fgn_pkg::NCFG_W-1:0];
				fgn_pkg::REG_NODES_Y:    reg_ny = d[fgn_pkg::NCFG_W-1:0];
				fgn_pkg::REG_OCTAVES:    reg_oct = d[fgn_pkg::OCT_CNT_W-1:0];
				fgn_pkg::REG_START_AMP:  reg_amp = d;
				fgn_pkg::REG_START_FREQ: reg_freq = d;
				default: ;
			endcase
		endfunction

		function int unsigned grid_size(int unsigned n);
			return (n < 2) ? 2 : (n > fgn_pkg::MAX_NODES) ? fgn_pkg::MAX_NODES : n;
		endfunction

		function longint mix(longint a, longint b, longint unsigned w);
			return a + (((b - a) * longint'(w)) >>> 16);
		endfunction

		function longint corner(int unsigned c, int unsigned r, longint ox, longint oy);
			int unsigned a;
			a = r * fgn_pkg::MAX_NODES + c;
			return ox * longint'(grid_gx[a]) + oy * longint'(grid_gy[a]);
		endfunction

		function longint cell_noise(longint unsigned cx, longint unsigned cy,
				int unsigned nx, int unsigned ny);
			int unsigned ix, iy;
			longint fx, fy, d0, d1, d2, d3;
			longint unsigned wx, wy;
			ix = cx >> 24;
			iy = cy >> 24;
			if (ix > nx - 2) ix = nx - 2;
			if (iy > ny - 2) iy = ny - 2;
			fx = (cx - (longint'(ix) << 24)) >> 8;
			fy = (cy - (longint'(iy) << 24)) >> 8;
			d0 = corner(ix, iy, -fx, -fy);
			d1 = corner(ix + 1, iy, 65536 - fx, -fy);
			d2 = corner(ix, iy + 1, -fx, 65536 - fy);
			d3 = corner(ix + 1, iy + 1, 65536 - fx, 65536 - fy);
			wx = blend_w[(fx + 128) >> 8];
			wy = blend_w[(fy + 128) >> 8];
			return mix(mix(d0, d1, wx), mix(d2, d3, wx), wy);
		endfunction

		function logic [fgn_pkg::HEIGHT_W-1:0] height_of(logic [fgn_pkg::PT_W-1:0] px,
				logic [fgn_pkg::PT_W-1:0] py);
			int unsigned nx, ny, oct, i;
			longint unsigned topx, topy, sx, sy, rx, ry, cx, cy;
			longint total, amp;
			nx = grid_size(reg_nx);
			ny = grid_size(reg_ny);
			oct = (reg_oct > fgn_pkg::MAX_OCTAVES) ? fgn_pkg::MAX_OCTAVES : reg_oct;
			topx = longint'(nx - 1) << 24;
			topy = longint'(ny - 1) << 24;
			sx = longint'(px) * reg_freq;
			sy = longint'(py) * reg_freq;
			rx = sx % topx;
			ry = sy % topy;
			amp = reg_amp;
			total = amp << 30;
			for (i = 0; i < oct; i++) begin
				// an exact nonzero multiple of the top stays at the top
				cx = (sx == 0) ? 0 : (rx == 0) ? topx : rx;
				cy = (sy == 0) ? 0 : (ry == 0) ? topy : ry;
				total += (cell_noise(cx, cy, nx, ny) * amp) >>> i;
				rx = (rx * 2) % topx;
				ry = (ry * 2) % topy;
			end
			if (total < 0) total = 0;
			if (total > (longint'(2) << 44)) total = longint'(2) << 44;
			return fgn_pkg::HEIGHT_W'(total >> 30);
		endfunction

		function void note_request(noise_req_t r);
			if (r.kind == fgn_pkg::REQ_WRITE) begin
				grid_gx[r.row * fgn_pkg::MAX_NODES + r.col] = r.gx;
				grid_gy[r.row * fgn_pkg::MAX_NODES + r.col] = r.gy;
				writes_seen++;
			end else begin
				owed_heights.push_back(height_of(r.px, r.py));
				evals_seen++;
			end
		endfunction

		task report_mismatch(string what);
			$display("[%0t] ERROR %s", $realtime, what);
			mismatches++;
		endtask

		task check_height(logic [fgn_pkg::HEIGHT_W-1:0] got);
			logic [fgn_pkg::HEIGHT_W-1:0] want;
			heights_seen++;
			if (owed_heights.size() == 0) begin
				report_mismatch($sformatf("height %0d with nothing pending", got));
			end else begin
				want = owed_heights.pop_front();
				if (got !== want)
					report_mismatch($sformatf("height %0d, predicted %0d", got, want));
			end
		endtask
	endclass

	logic clk, arst_n;
	logic                           cfg_we;
	logic [fgn_pkg::CFG_IDX_W-1:0]  cfg_idx;
	logic [fgn_pkg::CFG_DATA_W-1:0] cfg_data;
	fgn_req_if req_ch();
	fgn_rsp_if rsp_ch();
	height_scoreboard board;
	int cycles;
	int stall_left;
	bit calm;  // when set, both sides run without gaps

	fractal_gradient_noise_core DUT (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// Mostly back to back, some short gaps, now and then a long one.
	function int gap_len();
		int d;
		if (calm) return 0;
		d = $urandom_range(0, 99);
		if (d < 65) return 0;
		if (d < 94) return $urandom_range(1, 3);
		return $urandom_range(8, 60);
	endfunction

	// Receiver: hold ready low for random stretches.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			rsp_ch.ready <= 1'b1;
			if ($urandom_range(0, 9) < 3) stall_left <= gap_len();
		end
	end

	// Score every height word the block hands over.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) board.check_height(rsp_ch.height);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Present one word, hold it until taken, then optionally drop valid.
	task send_word(noise_req_t r);
		int g;
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= r.kind;
		req_ch.node_col <= r.col;
		req_ch.node_row <= r.row;
		req_ch.grad_x   <= r.gx;
		req_ch.grad_y   <= r.gy;
		req_ch.point_x  <= r.px;
		req_ch.point_y  <= r.py;
		do @(posedge clk); while (!req_ch.ready);
		board.note_request(r);
		g = gap_len();
		if (g > 0) begin
			req_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task write_grad(int c, int r, int gx, int gy);
		noise_req_t w;
		w.kind = fgn_pkg::REQ_WRITE;
		w.col = fgn_pkg::NODE_W'(c);
		w.row = fgn_pkg::NODE_W'(r);
		w.gx = fgn_pkg::GRAD_W'(gx);
		w.gy = fgn_pkg::GRAD_W'(gy);
		w.px = fgn_pkg::PT_W'($urandom());
		w.py = fgn_pkg::PT_W'($urandom());
		send_word(w);
	endtask

	task eval_point(logic [fgn_pkg::PT_W-1:0] px, logic [fgn_pkg::PT_W-1:0] py);
		noise_req_t e;
		e.kind = fgn_pkg::REQ_EVAL;
		e.col = fgn_pkg::NODE_W'($urandom());
		e.row = fgn_pkg::NODE_W'($urandom());
		e.gx = fgn_pkg::GRAD_W'($urandom());
		e.gy = fgn_pkg::GRAD_W'($urandom());
		e.px = px;
		e.py = py;
		send_word(e);
	endtask

	// Wait until every height is in, then let a trailing write settle.
	task drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (board.owed_heights.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task set_reg(logic [fgn_pkg::CFG_IDX_W-1:0] idx, int d);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= fgn_pkg::CFG_DATA_W'(d);
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_reg(idx, fgn_pkg::CFG_DATA_W'(d));
	endtask

	task set_all(int nx, int ny, int oct, int amp, int freq);
		set_reg(fgn_pkg::REG_NODES_X, nx);
		set_reg(fgn_pkg::REG_NODES_Y, ny);
		set_reg(fgn_pkg::REG_OCTAVES, oct);
		set_reg(fgn_pkg::REG_START_AMP, amp);
		set_reg(fgn_pkg::REG_START_FREQ, freq);
	endtask

	function logic [fgn_pkg::PT_W-1:0] pick_point(int unsigned top);
		int d;
		d = $urandom_range(0, 9);
		if (d < 4) return fgn_pkg::PT_W'($urandom());
		if (d < 8) return fgn_pkg::PT_W'($urandom_range(0, (top - 1) << 16));
		// whole-cell multiples of the top edge
		return fgn_pkg::PT_W'(((top - 1) * $urandom_range(0, 4)) << 16);
	endfunction

	// Node counts in force here must stay within the loaded corner.
	task random_run(int count);
		int n, nxe, nye;
		nxe = board.grid_size(board.reg_nx);
		nye = board.grid_size(board.reg_ny);
		for (n = 0; n < count; n++) begin
			if (n == count / 2) drain();  // sender waits for every height
			calm = (n % 100) >= 80;
			if ($urandom_range(0, 3) == 0)
				write_grad($urandom_range(0, fgn_pkg::MAX_NODES - 1),
					$urandom_range(0, fgn_pkg::MAX_NODES - 1),
					$urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384);
			else
				eval_point(pick_point(nxe), pick_point(nye));
		end
		calm = 1'b0;
		drain();
	endtask

	initial begin
		int c, r;
		board = new();
		cycles = 0;
		calm = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= fgn_pkg::REG_NODES_X;
		cfg_data <= '0;
		req_ch.valid <= 1'b0;
		req_ch.req_type <= fgn_pkg::REQ_WRITE;
		req_ch.node_col <= '0;
		req_ch.node_row <= '0;
		req_ch.grad_x <= '0;
		req_ch.grad_y <= '0;
		req_ch.point_x <= '0;
		req_ch.point_y <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Load the corner of the grid that every evaluate below stays in.
		calm = 1'b1;
		for (r = 0; r < LOAD_SIDE; r++)
			for (c = 0; c < LOAD_SIDE; c++)
				write_grad(c, r, $urandom_range(0, 32768) - 16384,
					$urandom_range(0, 32768) - 16384);
		calm = 1'b0;

		// Directed: extreme gradients, the highest node index.
		write_grad(0, 0, 16384, -16384);
		write_grad(LOAD_SIDE - 1, LOAD_SIDE - 1, -16384, 16384);
		write_grad(fgn_pkg::MAX_NODES - 1, fgn_pkg::MAX_NODES - 1, -16384, 16384);
		write_grad(1, 1, 0, 0);
		// Reset settings; points low enough that four doublings stay loaded.
		eval_point(0, 0);
		eval_point(24'h028000, 24'h020000);
		eval_point(24'h000001, 0);              // one coordinate zero
		eval_point(24'h00FFFF, 24'h018000);
		drain();
		// Spare register indexes must leave the settings alone.
		set_reg(REG_SPARE_LO, 16'hFFFF);
		set_reg(REG_SPARE_HI, 16'h0000);
		eval_point(24'h012345, 24'h023456);
		drain();
		// Exact top edge stays on top, also after wrapping.
		set_all(LOAD_SIDE, LOAD_SIDE, 2, 8192, 256);
		eval_point(fgn_pkg::PT_W'((LOAD_SIDE - 1) << 16),
			fgn_pkg::PT_W'((LOAD_SIDE - 1) << 16));
		eval_point(fgn_pkg::PT_W'((2 * (LOAD_SIDE - 1)) << 16), 24'h008000);
		eval_point(24'hFFFFFF, 24'hFFFFFF);
		drain();
		// Node counts above the maximum, one octave near the origin.
		set_all(127, 127, 1, 8192, 256);
		eval_point(24'h100000, 24'h0A8000);
		drain();
		// Out-of-range node counts and octaves, zero frequency and amplitude.
		set_all(0, 127, 31, 0, 0);
		eval_point(24'hABCDEF, 24'h012345);
		eval_point(24'h010000, 24'h020000);
		drain();
		set_all(1, 100, 0, 65535, 65535);
		eval_point(24'hFFFFFF, 24'h000000);
		eval_point(24'h00C000, 24'h7FFFFF);
		drain();
		set_all(2, 2, 16, 65535, 65535);
		eval_point(24'h010000, 24'h010000);
		eval_point(24'h00FFFF, 24'h800000);
		drain();

		// Random phases over several settings, extremes among them.
		set_all(LOAD_SIDE, LOAD_SIDE, 4, 8192, 256); random_run(200);
		set_all(2, 2, 16, 65535, 65535);             random_run(150);
		set_all(0, LOAD_SIDE, 1, 16384, 512);        random_run(150);
		set_all(17, 5, 0, 65535, 300);               random_run(100);
		set_all(LOAD_SIDE, 0, 31, 3000, 1000);       random_run(150);
		set_all(13, LOAD_SIDE, 3, $urandom_range(0, 65535), $urandom_range(0, 65535));
		random_run(150);
		set_all(9, 20, 6, 12000, 128);               random_run(150);

		drain();
		if (board.owed_heights.size() != 0)
			board.report_mismatch($sformatf("%0d heights never came",
				board.owed_heights.size()));
		$display("covered %0d gradient writes and %0d evaluations, %0d heights checked",
			board.writes_seen, board.evals_seen, board.heights_seen);
		$display("settings swept grid sizes 2..64, octaves 0..16, amplitude and scale extremes");
		if (board.mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

>>> fractal_gradient_noise_core.f
src/fgn_pkg.sv
src/fgn_req_if.sv
src/fgn_rsp_if.sv
src/fgn_ram.sv
src/fgn_ctrl.sv
src/fgn_dp.sv
src/fractal_gradient_noise_core.sv
verif/tb.sv
